@@ hw/rtl/rolling_majority_vote_filter_assert.svh @@
// Assertion macros shared by the majority vote filter RTL.
`ifndef ROLLING_MAJORITY_VOTE_FILTER_ASSERT_SVH
`define ROLLING_MAJORITY_VOTE_FILTER_ASSERT_SVH
`ifndef SYNTHESIS
`define RMVF_ASSERT_IMP(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("rmvf: same-cycle check failed");
`define RMVF_ASSERT_NXT(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("rmvf: next-cycle check failed");
`else
`define RMVF_ASSERT_IMP(name, clk, rst, ante, cons)
`define RMVF_ASSERT_NXT(name, clk, rst, ante, cons)
`endif
`endif

@@ hw/rtl/rmvf_pkg.sv @@
// Package: types and constants of the majority vote filter.
`timescale 1ns / 1ps
`default_nettype none
package rmvf_pkg;

  localparam int DEF_WINDOW  = 5;
  localparam int DEF_CLASSES = 5;
  localparam int CLASS_W     = 3;
  localparam int THR_W       = 3;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DEC,
    ST_INC,
    ST_SCAN,
    ST_DONE
  } state_t;

  typedef enum logic [1:0] {
    CNT_NOP,
    CNT_INC,
    CNT_DEC
  } cnt_op_t;

endpackage
`default_nettype wire

@@ hw/rtl/rmvf_vote_counts.sv @@
// Per-class vote counters with one shared read/modify/write port.
`timescale 1ns / 1ps
`default_nettype none
`include "rolling_majority_vote_filter_assert.svh"
module rmvf_vote_counts
  import rmvf_pkg::*;
#(
  parameter int WINDOW  = DEF_WINDOW,
  parameter int CLASSES = DEF_CLASSES,
  localparam int CW     = (CLASSES > 1) ? $clog2(CLASSES) : 1,
  localparam int CNTW   = $clog2(WINDOW + 1)
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire cnt_op_t         op,
  input  wire logic [CW-1:0]   addr,
  output logic      [CNTW-1:0] rd_count
);

  logic [CNTW-1:0] counts [CLASSES];

  assign rd_count = counts[addr];

  always_ff @(posedge clk) begin
    if (rst) begin
      // match the reset window: one vote for class 1, the rest for class 0
      for (int i = 0; i < CLASSES; i++) begin
        if (i == 0) begin
          counts[i] <= CNTW'(WINDOW - 1);
        end else if (i == 1) begin
          counts[i] <= CNTW'(1);
        end else begin
          counts[i] <= '0;
        end
      end
    end else begin
      unique case (op)
        CNT_INC: counts[addr] <= rd_count + CNTW'(1);
        CNT_DEC: begin
          if (rd_count != '0) begin
            counts[addr] <= rd_count - CNTW'(1);
          end
        end
        default: ;
      endcase
    end
  end

  `RMVF_ASSERT_IMP(a_no_underflow, clk, rst, op == CNT_DEC, rd_count != '0)
  `RMVF_ASSERT_IMP(a_no_overflow, clk, rst, op == CNT_INC, rd_count < CNTW'(WINDOW))

endmodule
`default_nettype wire

@@ hw/rtl/rolling_majority_vote_filter.sv @@
// Top level: sliding-window majority vote filter for classifier decisions.
//
// Input channel (in_valid/in_ready): class_id and no_result, one decision
// per item. Output channel (out_valid/out_ready): reported_class and
// class_changed, exactly one result item per input item, in order.
// cfg_we/cfg_data write majority_threshold; write it only while idle.
//
// A sequencer runs each decision through a single count port: retire the
// oldest vote, add the new one, then scan the CLASSES counters one per
// cycle for the leader. The next decision is accepted only once this one
// has passed to the output register; a no-result or out-of-range decision
// skips the count and scan steps.
// The result lands in an output register from the done state; the
// next item is accepted while that result waits. If the receiver stalls,
// the following result holds in the sequencer until the register frees.
//
// Reset: window holds class 1 then zeros, counts match it, the current
// class is 1 and the threshold is (WINDOW + 1) / 2.
`timescale 1ns / 1ps
`default_nettype none
`include "rolling_majority_vote_filter_assert.svh"
module rolling_majority_vote_filter
  import rmvf_pkg::*;
#(
  parameter int WINDOW  = DEF_WINDOW,
  parameter int CLASSES = DEF_CLASSES
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               cfg_we,
  input  wire logic [THR_W-1:0]   cfg_data,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic [CLASS_W-1:0] class_id,
  input  wire logic               no_result,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic      [CLASS_W-1:0] reported_class,
  output logic                    class_changed
);

  localparam int CW   = (CLASSES > 1) ? $clog2(CLASSES) : 1;
  localparam int CNTW = $clog2(WINDOW + 1);
  localparam int CXW  = (CW > CLASS_W) ? CW : CLASS_W;
  localparam int CMPW = (CNTW > THR_W) ? CNTW : THR_W;

  state_t             state, state_next;
  logic [THR_W-1:0]   thr;
  logic [CLASS_W-1:0] hist [WINDOW];
  logic [CLASS_W-1:0] cls_q;
  logic               scan_req;
  logic [CW-1:0]      scan_idx;
  logic [CNTW-1:0]    best_val;
  logic [CW-1:0]      best_cls;
  logic [CLASS_W-1:0] current_class;

  cnt_op_t            op;
  logic [CW-1:0]      addr;
  logic [CNTW-1:0]    rd_count;
  logic               load;
  logic               in_fire;
  logic               in_good;
  logic               scan_last;
  logic               win;
  logic [CXW-1:0]     cls_ext, old_ext, best_ext;

  assign in_fire   = in_valid && in_ready;
  assign in_good   = !no_result && (32'(class_id) < CLASSES);
  assign scan_last = (scan_idx == CW'(CLASSES - 1));
  assign cls_ext   = CXW'(cls_q);
  assign old_ext   = CXW'(hist[0]);
  assign best_ext  = CXW'(best_cls);
  assign win       = scan_req && (CMPW'(best_val) >= CMPW'(thr))
                     && (best_ext != CXW'(current_class));

  rmvf_vote_counts #(
    .WINDOW  (WINDOW),
    .CLASSES (CLASSES)
  ) u_counts (
    .clk      (clk),
    .rst      (rst),
    .op       (op),
    .addr     (addr),
    .rd_count (rd_count)
  );

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_fire) begin
          state_next = in_good ? ST_DEC : ST_DONE;
        end
      end
      ST_DEC:  state_next = ST_INC;
      ST_INC:  state_next = ST_SCAN;
      ST_SCAN: begin
        if (scan_last) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (load) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready = 1'b0;
    op       = CNT_NOP;
    addr     = scan_idx;
    load     = 1'b0;
    unique case (state)
      ST_IDLE: in_ready = 1'b1;
      ST_DEC: begin
        addr = old_ext[CW-1:0];
        if (32'(hist[0]) < CLASSES) begin
          op = CNT_DEC;
        end
      end
      ST_INC: begin
        addr = cls_ext[CW-1:0];
        op   = CNT_INC;
      end
      ST_SCAN: addr = scan_idx;
      ST_DONE: load = !out_valid || out_ready;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      thr           <= THR_W'((WINDOW + 1) / 2);
      current_class <= CLASS_W'(1);
      out_valid     <= 1'b0;
      scan_req      <= 1'b0;
      scan_idx      <= '0;
      for (int i = 0; i < WINDOW; i++) begin
        hist[i] <= (i == 0) ? CLASS_W'(1) : '0;
      end
    end else begin
      state <= state_next;
      if (cfg_we) begin
        thr <= cfg_data;
      end
      if (in_fire) begin
        scan_req <= in_good && (class_id != current_class);
      end
      // drop the oldest vote, append the new one
      if (state == ST_DEC) begin
        for (int i = 0; i < WINDOW - 1; i++) begin
          hist[i] <= hist[i + 1];
        end
        hist[WINDOW - 1] <= cls_q;
      end
      if (state == ST_INC) begin
        scan_idx <= '0;
      end else if (state == ST_SCAN && !scan_last) begin
        scan_idx <= scan_idx + CW'(1);
      end
      if (load) begin
        out_valid <= 1'b1;
        if (win) begin
          current_class <= best_ext[CLASS_W-1:0];
        end
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      cls_q <= class_id;
    end
    // strict compare keeps the lowest class on a tie
    if (state == ST_SCAN && (scan_idx == '0 || rd_count > best_val)) begin
      best_val <= rd_count;
      best_cls <= scan_idx;
    end
    if (load) begin
      reported_class <= win ? best_ext[CLASS_W-1:0] : current_class;
      class_changed  <= win;
    end
  end

  `RMVF_ASSERT_NXT(a_busy_after_accept, clk, rst, in_fire, !in_ready)
  `RMVF_ASSERT_NXT(a_skip_path, clk, rst, in_fire && !in_good, state == ST_DONE)
  `RMVF_ASSERT_IMP(a_out_matches_state, clk, rst, out_valid, reported_class == current_class)

endmodule
`default_nettype wire
